>>> hdl/agsa_pkg.sv
// shared types and constants for the argmax gradient scatter-add block
// used by every module under hdl; depends on nothing else
`default_nettype none

package agsa_pkg;

	// store geometry and value format
	localparam int STORE_DEPTH = 4096;
	localparam int VALUE_BITS  = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// field widths
	localparam int MODE_W     = 2;
	localparam int GRAD_W     = 32;
	localparam int OFF_W      = 12;
	localparam int CNT_W      = 12;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_W      = 32;
	localparam int EPOCH_W    = 4;

	// adder width covers both operands plus a carry
	localparam int SUM_W = ((VALUE_BITS > GRAD_W) ? VALUE_BITS : GRAD_W) + 1;
	// batch times plane size plus offset
	localparam int TGT_W = CNT_W + CFG_W + 1;

	// transaction modes
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACC   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_X_PLANE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DY_PLANE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BATCH    = 2'd2;

	// epoch tags: zero marks a swept entry, live epochs run first..last
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	// saturation bounds in adder width
	localparam logic signed [SUM_W-1:0] VAL_MAX =
		SUM_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] VAL_MIN = -VAL_MAX - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] OUT_MAX =
		SUM_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] OUT_MIN = -OUT_MAX - SUM_W'(1);

	typedef logic [EPOCH_W-1:0] epoch_t;

	typedef struct packed {
		logic [CFG_W-1:0] x_plane_elems;
		logic [CFG_W-1:0] dy_plane_elems;
		logic [CFG_W-1:0] batch_count;
	} cfg_t;

	// one store word: epoch tag and accumulated value
	typedef struct packed {
		epoch_t                tag;
		logic [VALUE_BITS-1:0] value;
	} word_t;

	// accepted transaction with the counter snapshot
	typedef struct packed {
		logic              valid;
		logic [MODE_W-1:0] mode;
		logic [GRAD_W-1:0] grad;
		logic [OFF_W-1:0]  offset;
		logic [OFF_W-1:0]  read_address;
		logic [CNT_W-1:0]  batch;
		epoch_t            epoch;
	} item_t;

	// transaction after address resolution
	typedef struct packed {
		logic              valid;
		logic [MODE_W-1:0] mode;
		logic [GRAD_W-1:0] grad;
		logic [ADDR_W-1:0] addr;
		logic              hit_ok;
		epoch_t            epoch;
	} stage_t;

	// store write request
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		word_t             word;
	} wr_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic              hold;
		epoch_t            epoch;
		logic              sweep_we;
		logic [ADDR_W-1:0] sweep_addr;
	} ctrl_t;

endpackage

`default_nettype wire

>>> hdl/agsa_store.sv
// accumulator store: one write port, one read port with registered data
// depends on agsa_pkg
`default_nettype none

module agsa_store import agsa_pkg::*; (
	input  logic              clk,
	input  wr_t               wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output word_t             rd_data
);

	word_t mem [STORE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.word;
		end
	end

	// read port, old data on a same-edge write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/agsa_ctrl.sv
// configuration registers, plane and batch counters, epoch and sweep sequencer
// depends on agsa_pkg
`default_nettype none

module agsa_ctrl import agsa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 accept,
	input  logic [MODE_W-1:0]    mode,
	input  logic                 pipe_busy,
	output cfg_t                 cfg,
	output logic [CNT_W-1:0]     batch,
	output ctrl_t                ctrl
);

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	localparam logic [CFG_W-1:0]  DY_LIMIT   = CFG_W'(1 << CNT_W);
	localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
	localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_DEPTH - 1);

	cfg_t              cfg_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  batch_q;
	epoch_t            epoch_q;
	logic [1:0]        state_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	logic [CFG_W-1:0]  len_eff;
	logic [CFG_W-1:0]  pos_inc;
	logic              pos_wrap;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_plane_elems  <= CFG_W'(1);
			cfg_q.dy_plane_elems <= CFG_W'(1);
			cfg_q.batch_count    <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_PLANE:  cfg_q.x_plane_elems  <= cfg_data;
				CFG_DY_PLANE: cfg_q.dy_plane_elems <= cfg_data;
				CFG_BATCH:    cfg_q.batch_count    <= cfg_data;
				default: ;
			endcase
		end
	end

	// dy plane length clamped to one..counter range
	always_comb begin
		if (cfg_q.dy_plane_elems == '0) begin
			len_eff = CFG_W'(1);
		end else if (cfg_q.dy_plane_elems > DY_LIMIT) begin
			len_eff = DY_LIMIT;
		end else begin
			len_eff = cfg_q.dy_plane_elems;
		end
	end

	assign pos_inc  = CFG_W'(pos_q) + CFG_W'(1);
	assign pos_wrap = (pos_inc >= len_eff);

	// plane position and batch number follow accepted transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			batch_q <= '0;
		end else if (accept) begin
			case (mode)
				MODE_CLEAR: begin
					pos_q   <= '0;
					batch_q <= '0;
				end
				MODE_ACC: begin
					if (pos_wrap) begin
						pos_q <= '0;
						if (batch_q != CNT_MAX) begin
							batch_q <= batch_q + CNT_W'(1);
						end
					end else begin
						pos_q <= pos_inc[CNT_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// epoch advance on clear; tag space exhausted -> drain then sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			epoch_q      <= EPOCH_FIRST;
			sweep_addr_q <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (accept && mode == MODE_CLEAR) begin
						if (epoch_q == EPOCH_LAST) begin
							state_q <= ST_DRAIN;
						end else begin
							epoch_q <= epoch_q + EPOCH_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q      <= ST_SWEEP;
						sweep_addr_q <= '0;
					end
				end
				ST_SWEEP: begin
					if (sweep_addr_q == SWEEP_LAST) begin
						state_q <= ST_RUN;
						epoch_q <= EPOCH_FIRST;
					end else begin
						sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	assign cfg             = cfg_q;
	assign batch           = batch_q;
	assign ctrl.hold       = (state_q != ST_RUN);
	assign ctrl.epoch      = epoch_q;
	assign ctrl.sweep_we   = (state_q == ST_SWEEP);
	assign ctrl.sweep_addr = sweep_addr_q;

`ifndef ASSERT_OFF
	// the sweep owns the write port only with the pipeline empty
	a_sweep_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> !pipe_busy)
		else $error("sweep running with transactions in flight");
`endif

endmodule

`default_nettype wire

>>> hdl/agsa_addr.sv
// first stage: target address and range checks, drives the store read
// depends on agsa_pkg
`default_nettype none

module agsa_addr import agsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  item_t             in_item,
	input  cfg_t              cfg,
	output logic              s1_busy,
	output logic [ADDR_W-1:0] rd_addr,
	output stage_t            stage_s2
);

	item_t            item_s1;
	logic [TGT_W-1:0] target;
	logic             drop;
	logic             read_ok;
	logic             hit_ok;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (adv) begin
			item_s1 <= in_item;
		end
	end

	// target entry and drop conditions
	always_comb begin
		target = TGT_W'(item_s1.batch) * TGT_W'(cfg.x_plane_elems)
			+ TGT_W'(item_s1.offset);
		drop = (CFG_W'(item_s1.offset) >= cfg.x_plane_elems)
			|| (CFG_W'(item_s1.batch) >= cfg.batch_count)
			|| (target >= TGT_W'(STORE_DEPTH));
		read_ok = (TGT_W'(item_s1.read_address) < TGT_W'(STORE_DEPTH));
		if (item_s1.mode == MODE_READ) begin
			rd_addr = ADDR_W'(item_s1.read_address);
			hit_ok  = read_ok;
		end else begin
			rd_addr = target[ADDR_W-1:0];
			hit_ok  = !drop;
		end
	end

	// second stage register, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
		end else if (adv) begin
			stage_s2.valid  <= item_s1.valid;
			stage_s2.mode   <= item_s1.mode;
			stage_s2.grad   <= item_s1.grad;
			stage_s2.addr   <= rd_addr;
			stage_s2.hit_ok <= hit_ok;
			stage_s2.epoch  <= item_s1.epoch;
		end
	end

	assign s1_busy = item_s1.valid;

endmodule

`default_nettype wire

>>> hdl/agsa_merge.sv
// second stage: forwarding, saturating add, write-back, drop flag, result register
// depends on agsa_pkg
`default_nettype none

module agsa_merge import agsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stage_t                stage_s2,
	input  word_t                 rd_data,
	input  logic                  flush,
	input  logic                  out_stall,
	output logic                  adv,
	output wr_t                   wr,
	output logic                  out_valid,
	output logic signed [OUT_W-1:0] read_value,
	output logic                  dropped_seen
);

	logic                  fwd_valid_q;
	logic [ADDR_W-1:0]     fwd_addr_q;
	word_t                 fwd_word_q;
	logic                  drop_flag_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      read_value_q;
	logic                  dropped_seen_q;
	word_t                 cur_word;
	logic                  entry_ok;
	logic signed [SUM_W-1:0] cur_ext;
	logic signed [SUM_W-1:0] grad_ext;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sum_sat;
	logic signed [SUM_W-1:0] rd_clamp;
	logic                  is_acc;
	logic                  is_read;

	assign is_acc  = stage_s2.valid && (stage_s2.mode == MODE_ACC);
	assign is_read = stage_s2.valid && (stage_s2.mode == MODE_READ);

	// pipeline holds only while a read result cannot leave
	assign adv = !(out_valid_q && out_stall && is_read);

	// newest write wins over the store read data
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == stage_s2.addr) begin
			cur_word = fwd_word_q;
		end else begin
			cur_word = rd_data;
		end
		entry_ok = stage_s2.hit_ok && (cur_word.tag == stage_s2.epoch);
		if (entry_ok) begin
			cur_ext = {{(SUM_W - VALUE_BITS){cur_word.value[VALUE_BITS-1]}}, cur_word.value};
		end else begin
			cur_ext = '0;
		end
		grad_ext = {{(SUM_W - GRAD_W){stage_s2.grad[GRAD_W-1]}}, stage_s2.grad};
		sum      = cur_ext + grad_ext;
	end

	// clamp the sum to the value range and the read to the port range
	always_comb begin
		if (sum > VAL_MAX) begin
			sum_sat = VAL_MAX;
		end else if (sum < VAL_MIN) begin
			sum_sat = VAL_MIN;
		end else begin
			sum_sat = sum;
		end
		if (cur_ext > OUT_MAX) begin
			rd_clamp = OUT_MAX;
		end else if (cur_ext < OUT_MIN) begin
			rd_clamp = OUT_MIN;
		end else begin
			rd_clamp = cur_ext;
		end
	end

	// write-back of an accepted accumulate
	always_comb begin
		wr.en         = adv && is_acc && stage_s2.hit_ok;
		wr.addr       = stage_s2.addr;
		wr.word.tag   = stage_s2.epoch;
		wr.word.value = sum_sat[VALUE_BITS-1:0];
	end

	// forwarding register tracks the last write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			fwd_addr_q  <= '0;
			fwd_word_q  <= '0;
		end else if (flush) begin
			fwd_valid_q <= 1'b0;
		end else if (wr.en) begin
			fwd_valid_q <= 1'b1;
			fwd_addr_q  <= wr.addr;
			fwd_word_q  <= wr.word;
		end
	end

	// sticky drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_flag_q <= 1'b0;
		end else if (adv && stage_s2.valid) begin
			if (stage_s2.mode == MODE_CLEAR) begin
				drop_flag_q <= 1'b0;
			end else if (is_acc && !stage_s2.hit_ok) begin
				drop_flag_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			read_value_q   <= '0;
			dropped_seen_q <= 1'b0;
		end else if (adv && is_read) begin
			out_valid_q    <= 1'b1;
			read_value_q   <= rd_clamp[OUT_W-1:0];
			dropped_seen_q <= drop_flag_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign dropped_seen = dropped_seen_q;

`ifndef ASSERT_OFF
	// tag zero is reserved for swept entries
	a_live_tag: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (wr.word.tag != '0))
		else $error("store write with the swept tag");

	// the flag only rises from a dropped accumulate
	a_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drop_flag_q) |-> $past(adv && is_acc && !stage_s2.hit_ok))
		else $error("drop flag set without a dropped accumulate");
`endif

endmodule

`default_nettype wire

>>> hdl/argmax_gradient_scatter_add_top.sv
// top level of the argmax gradient scatter-add block
// depends on agsa_pkg, agsa_ctrl, agsa_addr, agsa_merge, agsa_store
//
// Usage:
// - in channel (in_valid/in_stall) carries mode, grad_value, argmax_offset and
//   read_address; mode clear empties the store and counters, accumulate adds
//   grad_value at batch * x_plane_elems + argmax_offset with saturation, read
//   returns one entry and the sticky drop flag
// - out channel (out_valid/out_stall) carries read_value and dropped_seen, one
//   transaction per read, none for clear or accumulate
// - one transaction per cycle while in_stall is low; a read result passes the input
//   register and the second stage register before it reaches the output register
// - the three-stage path is input register, store read, merge and result
//   register; a read-modify-write uses forwarding so back-to-back hits
//   on one entry run at full rate
// - clears use epoch tags; every fifteenth clear waits for the pipeline to
//   drain and then sweeps all STORE_DEPTH (4096) store entries, in_stall high
//   from the clear to the end of the sweep
// - after reset the same sweep runs with in_stall high, and no transaction is
//   taken before it ends; configuration writes are taken at any time
// - while a read result waits under out_stall, transactions keep flowing until
//   the next read reaches the last stage, then in_stall rises
`default_nettype none

module argmax_gradient_scatter_add_top import agsa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MODE_W-1:0]       mode,
	input  logic signed [GRAD_W-1:0] grad_value,
	input  logic [OFF_W-1:0]        argmax_offset,
	input  logic [OFF_W-1:0]        read_address,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] read_value,
	output logic                    dropped_seen
);

	cfg_t              cfg;
	ctrl_t             ctrl;
	logic [CNT_W-1:0]  batch;
	logic              accept;
	logic              adv;
	logic              s1_busy;
	logic              pipe_busy;
	item_t             in_item;
	stage_t            stage_s2;
	logic [ADDR_W-1:0] rd_addr;
	word_t             rd_data;
	wr_t               wr_pipe;
	wr_t               wr_mem;

	// input handshake
	assign in_stall  = ctrl.hold || !adv;
	assign accept    = in_valid && !in_stall;
	assign pipe_busy = s1_busy || stage_s2.valid;

	// transaction with counter snapshot
	always_comb begin
		in_item.valid        = accept;
		in_item.mode         = mode;
		in_item.grad         = grad_value;
		in_item.offset       = argmax_offset;
		in_item.read_address = read_address;
		in_item.batch        = batch;
		in_item.epoch        = ctrl.epoch;
	end

	agsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.mode      (mode),
		.pipe_busy (pipe_busy),
		.cfg       (cfg),
		.batch     (batch),
		.ctrl      (ctrl)
	);

	agsa_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_item  (in_item),
		.cfg      (cfg),
		.s1_busy  (s1_busy),
		.rd_addr  (rd_addr),
		.stage_s2 (stage_s2)
	);

	agsa_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_s2     (stage_s2),
		.rd_data      (rd_data),
		.flush        (ctrl.sweep_we),
		.out_stall    (out_stall),
		.adv          (adv),
		.wr           (wr_pipe),
		.out_valid    (out_valid),
		.read_value   (read_value),
		.dropped_seen (dropped_seen)
	);

	// sweep takes the write port while the pipeline is empty
	always_comb begin
		if (ctrl.sweep_we) begin
			wr_mem.en   = 1'b1;
			wr_mem.addr = ctrl.sweep_addr;
			wr_mem.word = '0;
		end else begin
			wr_mem = wr_pipe;
		end
	end

	agsa_store u_store (
		.clk     (clk),
		.wr      (wr_mem),
		.rd_en   (adv),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

`ifndef ASSERT_OFF
	// sweep and write-back never compete for the write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.sweep_we && wr_pipe.en))
		else $error("sweep and write-back in the same cycle");
`endif

endmodule

`default_nettype wire
